>>> sv/etf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and constants of the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package etf_pkg;

    // fixed field widths
    localparam int COORD_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int RADIUS_W = 31;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_CONST_RE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_CONST_IM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_RADIUS  = 3'd4;

    // reset values
    localparam logic [COUNT_W-1:0]  ITER_LIMIT_RST    = 7'd64;
    localparam logic [RADIUS_W-1:0] ESCAPE_RADIUS_RST = 31'h2000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;

    // word handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                done;
        logic                escaped;
        logic [COUNT_W-1:0]  count;
        t_coord              zr;
        t_coord              zi;
        t_coord              cr;
        t_coord              ci;
    } t_cell_word;

    // settings every cell sees
    typedef struct packed {
        logic [COUNT_W-1:0] limit;
        logic [R2_W-1:0]    r2;
    } t_cell_cfg;

endpackage
`default_nettype wire

>>> sv/etf_point_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_point_if
// Input channel: one complex point per word.
// ----------------------------------------------------------------------------
interface etf_point_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    point_re;
    logic signed [31:0]    point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink   (input valid, input point_re, input point_im, output ready);
endinterface
`default_nettype wire

>>> sv/etf_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_result_if
// Output channel: escape iteration and escape flag per word.
// ----------------------------------------------------------------------------
interface etf_result_if;
    logic        valid;
    logic        ready;
    logic [6:0]  iteration_count;
    logic        escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface
`default_nettype wire

>>> sv/etf_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface etf_cfg_if;
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [31:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/etf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_cell
// One iteration z = z*z + c in two stages: products, then escape test,
// limit test and the new z with overflow check.
// ----------------------------------------------------------------------------
module etf_cell
    import etf_pkg::*;
#(
    parameter int K             = 0,
    parameter int FRACTION_BITS = 28
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire t_cell_cfg  i_cfg,
    input  wire t_cell_word i_word,
    output t_cell_word      o_word
);

    // position of this cell relative to the 7-bit limit
    localparam bit                 K_BIG    = (K > 127);
    localparam logic [COUNT_W-1:0] K_CNT    = COUNT_W'(K_BIG ? 127 : K);
    localparam logic [COUNT_W-1:0] K_PREV   = COUNT_W'(K > 0 ? K - 1 : 0);
    localparam bit                 HAS_PREV = (K > 0);

    t_cell_word r_a_word;
    t_prod      r_p_rr;
    t_prod      r_p_ii;
    t_prod      r_p_ri;
    t_cell_word r_b_word;
    t_cell_word n_b_word;

    // stage A: exact products of incoming z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_word.valid <= 1'b0;
        end else if (i_en) begin
            r_a_word.valid <= i_word.valid;
        end
        if (i_en) begin
            r_a_word.done    <= i_word.done;
            r_a_word.escaped <= i_word.escaped;
            r_a_word.count   <= i_word.count;
            r_a_word.zr      <= i_word.zr;
            r_a_word.zi      <= i_word.zi;
            r_a_word.cr      <= i_word.cr;
            r_a_word.ci      <= i_word.ci;
            r_p_rr           <= PROD_W'(i_word.zr) * PROD_W'(i_word.zr);
            r_p_ii           <= PROD_W'(i_word.zi) * PROD_W'(i_word.zi);
            r_p_ri           <= PROD_W'(i_word.zr) * PROD_W'(i_word.zi);
        end
    end

    // stage B datapath
    logic [PROD_W:0]       mag_sum;
    logic                  mag_esc;
    logic                  at_limit;
    t_prod                 rr_s;
    t_prod                 ii_s;
    t_prod                 ri_s;
    logic signed [PROD_W+1:0] nr;
    logic signed [PROD_W+1:0] ni;
    logic                  ovf;

    always_comb begin
        // squared modulus of incoming z, exact
        mag_sum  = {1'b0, r_p_rr} + {1'b0, r_p_ii};
        mag_esc  = HAS_PREV && (mag_sum > (PROD_W+1)'(i_cfg.r2));
        at_limit = K_BIG || (K_CNT >= i_cfg.limit);

        // floor-scaled products and the next z
        rr_s = r_p_rr >>> FRACTION_BITS;
        ii_s = r_p_ii >>> FRACTION_BITS;
        ri_s = r_p_ri >>> (FRACTION_BITS - 1);
        nr   = (PROD_W+2)'(rr_s) - (PROD_W+2)'(ii_s) + (PROD_W+2)'(r_a_word.cr);
        ni   = (PROD_W+2)'(ri_s) + (PROD_W+2)'(r_a_word.ci);
        ovf  = (nr != (PROD_W+2)'(nr[COORD_W-1:0] ^ {1'b1, {(COORD_W-1){1'b0}}})
                      - (PROD_W+2)'({1'b1, {(COORD_W-1){1'b0}}}))
            || (ni != (PROD_W+2)'(ni[COORD_W-1:0] ^ {1'b1, {(COORD_W-1){1'b0}}})
                      - (PROD_W+2)'({1'b1, {(COORD_W-1){1'b0}}}));

        n_b_word = r_a_word;
        if (!r_a_word.done) begin
            if (mag_esc) begin
                n_b_word.done    = 1'b1;
                n_b_word.escaped = 1'b1;
                n_b_word.count   = K_PREV;
            end else if (at_limit) begin
                n_b_word.done    = 1'b1;
                n_b_word.escaped = 1'b0;
                n_b_word.count   = i_cfg.limit;
            end else if (ovf) begin
                n_b_word.done    = 1'b1;
                n_b_word.escaped = 1'b1;
                n_b_word.count   = K_CNT;
            end else begin
                n_b_word.zr = nr[COORD_W-1:0];
                n_b_word.zi = ni[COORD_W-1:0];
            end
        end
    end

    // stage B register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_word.valid <= 1'b0;
        end else if (i_en) begin
            r_b_word.valid <= n_b_word.valid;
        end
        if (i_en) begin
            r_b_word.done    <= n_b_word.done;
            r_b_word.escaped <= n_b_word.escaped;
            r_b_word.count   <= n_b_word.count;
            r_b_word.zr      <= n_b_word.zr;
            r_b_word.zi      <= n_b_word.zi;
            r_b_word.cr      <= n_b_word.cr;
            r_b_word.ci      <= n_b_word.ci;
        end
    end

    assign o_word = r_b_word;

endmodule
`default_nettype wire

>>> sv/escape_time_fractal_iterator.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted point passes stage A and stage B of every cell on its way out.
// Throughput: one point per cycle while the output is not stalled; the row has
// one two-stage cell per iteration plus a final cell that runs the last escape
// test. A stalled output freezes the whole row of cells.
// Reset (synchronous, active low) empties the row and loads the register
// reset values; the squared radius follows in the cycle after reset.
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Mandelbrot / Julia escape-time iterator in signed fixed point, built as a
// row of iteration cells.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator
    import etf_pkg::*;
#(
    parameter int MAX_ITERATIONS = 64,
    parameter int FRACTION_BITS  = 28
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    etf_point_if.sink     i_point,
    etf_result_if.source  o_result,
    etf_cfg_if.sink       i_cfg
);

    localparam int N_CELLS = MAX_ITERATIONS + 1;
    localparam logic [COUNT_W-1:0] MAX_CNT =
        COUNT_W'(MAX_ITERATIONS > 127 ? 127 : MAX_ITERATIONS);

    // configuration registers
    logic                 r_julia_mode;
    t_coord               r_julia_const_re;
    t_coord               r_julia_const_im;
    logic [COUNT_W-1:0]   r_iteration_limit;
    logic [RADIUS_W-1:0]  r_escape_radius;
    t_cell_cfg            r_cell_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_julia_mode      <= 1'b0;
            r_julia_const_re  <= '0;
            r_julia_const_im  <= '0;
            r_iteration_limit <= ITER_LIMIT_RST;
            r_escape_radius   <= ESCAPE_RADIUS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_JULIA_MODE:     r_julia_mode      <= i_cfg.data[0];
                REG_JULIA_CONST_RE: r_julia_const_re  <= i_cfg.data;
                REG_JULIA_CONST_IM: r_julia_const_im  <= i_cfg.data;
                REG_ITER_LIMIT:     r_iteration_limit <= i_cfg.data[COUNT_W-1:0];
                REG_ESCAPE_RADIUS:  r_escape_radius   <= i_cfg.data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective limit and squared radius, registered
    always_ff @(posedge i_clk) begin
        r_cell_cfg.limit <= (r_iteration_limit > MAX_CNT) ? MAX_CNT : r_iteration_limit;
        r_cell_cfg.r2    <= R2_W'(r_escape_radius) * R2_W'(r_escape_radius);
    end

    // row of cells, frozen as a whole when the result word is stalled
    t_cell_word w [0:N_CELLS];
    logic       en;

    assign en            = !w[N_CELLS].valid || o_result.ready;
    assign i_point.ready = en;

    always_comb begin
        w[0].valid   = i_point.valid;
        w[0].done    = 1'b0;
        w[0].escaped = 1'b0;
        w[0].count   = '0;
        if (r_julia_mode) begin
            w[0].zr = i_point.point_re;
            w[0].zi = i_point.point_im;
            w[0].cr = r_julia_const_re;
            w[0].ci = r_julia_const_im;
        end else begin
            w[0].zr = '0;
            w[0].zi = '0;
            w[0].cr = i_point.point_re;
            w[0].ci = i_point.point_im;
        end
    end

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        etf_cell #(
            .K             (k),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cfg   (r_cell_cfg),
            .i_word  (w[k]),
            .o_word  (w[k+1])
        );
    end

    // result word
    assign o_result.valid           = w[N_CELLS].valid;
    assign o_result.iteration_count = w[N_CELLS].count;
    assign o_result.escaped         = w[N_CELLS].escaped;

endmodule
`default_nettype wire

>>> test/escape_time_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_checker
// Watches the point, result and register channels of the fractal iterator.
// Mirrors the register writes, works out the escape outcome of every accepted
// point and compares each result word, in order, with the oldest outcome.
// ----------------------------------------------------------------------------
module escape_time_checker
    import etf_pkg::*;
#(
    parameter int MAX_ITERATIONS = 64,
    parameter int FRACTION_BITS  = 28
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    etf_point_if      i_point,
    etf_result_if     o_result,
    etf_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam longint COORD_HI = 64'sh7FFF_FFFF;
    localparam longint COORD_LO = -64'sh8000_0000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               escaped;
    } t_outcome;

    // mirrored register file
    logic                julia_on;
    t_coord              julia_c_re;
    t_coord              julia_c_im;
    logic [COUNT_W-1:0]  iter_limit;
    logic [RADIUS_W-1:0] radius;

    t_outcome awaited_outcomes[$];
    t_outcome oldest;
    int       fails;
    int       checked;

    function automatic bit [63:0] modulus_sq(input longint v);
        bit [63:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    // iterate z = z*z + c until escape, overflow or the limit
    function automatic t_outcome escape_outcome(input t_coord p_re, input t_coord p_im);
        longint    zr, zi, cr, ci, nr, ni;
        bit [63:0] r2;
        int        lim;
        int        n;
        t_outcome  res;
        lim = int'(iter_limit);
        if (lim > MAX_ITERATIONS) lim = MAX_ITERATIONS;
        r2 = 64'(radius) * 64'(radius);
        if (julia_on) begin
            zr = longint'(p_re);
            zi = longint'(p_im);
            cr = longint'(julia_c_re);
            ci = longint'(julia_c_im);
        end else begin
            zr = 0;
            zi = 0;
            cr = longint'(p_re);
            ci = longint'(p_im);
        end
        res.count   = COUNT_W'(lim);
        res.escaped = 1'b0;
        for (n = 0; n < lim; n++) begin
            // products are exact; shifts round toward minus infinity
            nr = ((zr * zr) >>> FRACTION_BITS) - ((zi * zi) >>> FRACTION_BITS) + cr;
            ni = ((zr * zi) >>> (FRACTION_BITS - 1)) + ci;
            // leaving the coordinate range counts as escape
            if (nr > COORD_HI || nr < COORD_LO || ni > COORD_HI || ni < COORD_LO) begin
                res.count   = COUNT_W'(n);
                res.escaped = 1'b1;
                return res;
            end
            zr = nr;
            zi = ni;
            if (modulus_sq(zr) + modulus_sq(zi) > r2) begin
                res.count   = COUNT_W'(n);
                res.escaped = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    // register mirror, prediction and comparison
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            julia_on   = 1'b0;
            julia_c_re = '0;
            julia_c_im = '0;
            iter_limit = ITER_LIMIT_RST;
            radius     = ESCAPE_RADIUS_RST;
            awaited_outcomes.delete();
            fails      = 0;
            checked    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_JULIA_MODE:     julia_on   = i_cfg.data[0];
                    REG_JULIA_CONST_RE: julia_c_re = i_cfg.data;
                    REG_JULIA_CONST_IM: julia_c_im = i_cfg.data;
                    REG_ITER_LIMIT:     iter_limit = i_cfg.data[COUNT_W-1:0];
                    REG_ESCAPE_RADIUS:  radius     = i_cfg.data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (i_point.valid && i_point.ready)
                awaited_outcomes.push_back(escape_outcome(i_point.point_re, i_point.point_im));
            if (o_result.valid && o_result.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word, count %0d escaped %0b", $time,
                             o_result.iteration_count, o_result.escaped);
                end else begin
                    oldest = awaited_outcomes.pop_front();
                    checked++;
                    if (o_result.iteration_count !== oldest.count) begin
                        fails++;
                        $display("%0t: iteration_count expected %0d actual %0d", $time,
                                 oldest.count, o_result.iteration_count);
                    end
                    if (o_result.escaped !== oldest.escaped) begin
                        fails++;
                        $display("%0t: escaped expected %0b actual %0b", $time,
                                 oldest.escaped, o_result.escaped);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_outcomes.size();
        o_checked    <= checked;
    end

endmodule

>>> test/tb_escape_time_fractal_iterator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator
// Drives points and register writes into the fractal iterator under random
// idling on both sides, with one long output hold that backs up the row.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator;
    import etf_pkg::*;

    localparam int MAX_ITERATIONS = 64;
    localparam int FRACTION_BITS  = 28;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 2 * (MAX_ITERATIONS + 1) + 20;

    // Q4.28 values
    localparam t_coord Q_ONE     = 32'sh1000_0000;
    localparam t_coord Q_TWO     = 32'sh2000_0000;
    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int  tx_gap_pct;
    int  rx_stall_pct;
    bit  hold_output;
    int  held;
    int  settings_loaded;
    int  failures;
    int  pending_words;
    int  checked_words;

    etf_point_if  point_if();
    etf_result_if result_if();
    etf_cfg_if    cfg_if();

    escape_time_fractal_iterator #(
        .MAX_ITERATIONS(MAX_ITERATIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (point_if),
        .o_result(result_if),
        .i_cfg   (cfg_if)
    );

    escape_time_checker #(
        .MAX_ITERATIONS(MAX_ITERATIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_point     (point_if),
        .o_result    (result_if),
        .i_cfg       (cfg_if),
        .o_fail_count(failures),
        .o_pending   (pending_words),
        .o_checked   (checked_words)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                hold_output = 1'b0;
                result_if.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // valid stays high from word to word unless a gap is drawn
    task automatic send_point(input t_coord re, input t_coord im);
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
            point_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        point_if.valid    <= 1'b1;
        point_if.point_re <= re;
        point_if.point_im <= im;
        do @(posedge i_clk); while (!point_if.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // mostly in [-2, 2), some in [-1, 1), a few anywhere or at the rails
    function automatic t_coord pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return t_coord'($urandom_range(0, 32'h3FFF_FFFF)) - Q_TWO;
            6, 7:             return t_coord'($urandom_range(0, 32'h1FFF_FFFF)) - Q_ONE;
            8:                return t_coord'($urandom);
            default:          return $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 3)
                                                          : COORD_MIN + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) send_point(pick_coord(), pick_coord());
    endtask

    // let the row empty, then rewrite all registers with random unused bits
    task automatic load_settings(input bit mode, input t_coord c_re, input t_coord c_im,
                                 input logic [COUNT_W-1:0] limit,
                                 input logic [RADIUS_W-1:0] radius);
        logic [31:0] noise;
        noise = $urandom;
        point_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        write_reg(REG_JULIA_MODE, {noise[31:1], mode});
        write_reg(REG_JULIA_CONST_RE, c_re);
        write_reg(REG_JULIA_CONST_IM, c_im);
        write_reg(REG_ITER_LIMIT, {noise[31:COUNT_W], limit});
        write_reg(REG_ESCAPE_RADIUS, {noise[0], radius});
        cfg_if.valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_settings();
        t_coord                c_re, c_im;
        logic [COUNT_W-1:0]    limit;
        logic [RADIUS_W-1:0]   radius;
        int                    r;
        c_re = ($urandom_range(0, 9) < 7) ? t_coord'($urandom_range(0, 32'h1FFF_FFFF)) - Q_ONE
                                          : t_coord'($urandom);
        c_im = ($urandom_range(0, 9) < 7) ? t_coord'($urandom_range(0, 32'h1FFF_FFFF)) - Q_ONE
                                          : t_coord'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)      limit = '0;
        else if (r == 1) limit = COUNT_W'($urandom_range(MAX_ITERATIONS + 1, 127));
        else             limit = COUNT_W'($urandom_range(1, MAX_ITERATIONS));
        r = $urandom_range(0, 9);
        if (r < 6)      radius = RADIUS_W'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF));
        else if (r < 8) radius = RADIUS_W'($urandom_range(0, 32'h1000_0000));
        else            radius = RADIUS_W'($urandom);
        load_settings($urandom_range(0, 1), c_re, c_im, limit, radius);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n           <= 1'b0;
        point_if.valid    <= 1'b0;
        point_if.point_re <= '0;
        point_if.point_im <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        tx_gap_pct        = 20;
        rx_stall_pct      = 20;
        hold_output       = 1'b0;
        settings_loaded   = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // writes to unused indexes must leave every register alone
        for (int k = int'(REG_ESCAPE_RADIUS) + 1; k < 8; k++)
            write_reg(CFG_IDX_W'(k), $urandom);
        cfg_if.valid <= 1'b0;

        // reset settings: Mandelbrot, limit 64, radius 2.0
        send_point('0, '0);
        send_point(-Q_TWO, '0);              // sits exactly on the radius forever
        send_point(Q_ONE >>> 2, '0);         // cusp, bounded
        send_point(Q_ONE, '0);
        send_point('0, Q_ONE);               // periodic orbit
        send_point(-Q_ONE, '0);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
        send_point(32'sh04CC_CCCD, 32'sh0800_0000);
        send_random(80);

        // zero radius, single iteration: only z = 0 stays
        load_settings(1'b0, '0, '0, 7'd1, '0);
        send_point('0, '0);
        send_point(32'sd1, '0);
        send_random(80);

        // limit above the maximum, full radius: orbits run into overflow
        load_settings(1'b0, '0, '0, 7'd127, 31'h7FFF_FFFF);
        send_point(32'sh2800_0000, '0);
        send_point(-32'sh2800_0000, '0);
        send_point('0, 32'sh2800_0000);
        // long output hold with a steady sender so the row backs up
        tx_gap_pct  = 0;
        hold_output = 1'b1;
        send_random(160);
        tx_gap_pct = 20;

        // Julia set with a common constant
        load_settings(1'b1, -32'sh0CCC_CCCD, 32'sh027E_FA3F, 7'd64, ESCAPE_RADIUS_RST);
        send_point('0, '0);
        send_point(32'sh1800_0000, '0);
        send_point(COORD_MAX, COORD_MIN);
        send_random(80);

        // Julia, constant at the rails, limit zero: no iteration runs
        load_settings(1'b1, COORD_MIN, COORD_MAX, 7'd0, ESCAPE_RADIUS_RST);
        send_point('0, '0);
        send_point(COORD_MIN, COORD_MAX);
        send_random(20);

        // random settings with varied idling
        for (int p = 0; p < 5; p++) begin
            random_settings();
            tx_gap_pct   = 15 * $urandom_range(0, 2);
            rx_stall_pct = 15 * $urandom_range(0, 2);
            send_random(70);
        end

        // closing stretch without idling
        random_settings();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_random(60);
        point_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d register settings in both modes, limits from zero to above",
                 settings_loaded);
        $display("the maximum and radii from zero to full scale; %0d result words checked.",
                 checked_words);
        if (failures == 0 && pending_words == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
